/* rtl/cumulative_key_node_deque_assert.svh */
// assertion macros for the node deque
`ifndef CUMULATIVE_KEY_NODE_DEQUE_ASSERT_SVH
`define CUMULATIVE_KEY_NODE_DEQUE_ASSERT_SVH

// same-cycle implication
`define CKN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication check failed");

// next-cycle implication
`define CKN_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

/* rtl/ckn_pkg.sv */
`timescale 1ns / 1ps

package ckn_pkg;

	localparam int CKN_CAPACITY = 50;

	localparam logic [2:0] KIND_CREATE     = 3'd0;
	localparam logic [2:0] KIND_PUSH_CUM   = 3'd1;
	localparam logic [2:0] KIND_PUSH_PLAIN = 3'd2;
	localparam logic [2:0] KIND_PUSH_LEFT  = 3'd3;
	localparam logic [2:0] KIND_POP_LEFT   = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] key;
		logic [31:0] page;
	} ckn_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] removed_size;
		logic [5:0]  entry_count;
		logic [31:0] first_page;
	} ckn_out_t;

endpackage

/* rtl/cumulative_key_node_deque.sv */
`timescale 1ns / 1ps
// Counted B+ tree inner node kept as a bounded deque of (page, cumulative key)
// entries. One operation enters on the in channel (valid/ready) and exactly one
// result leaves on the out channel (valid/ready), in order.
// Operations: create, push right cumulative, push right plain, push left,
// pop left. A push on a full node reports full, a pop on an empty node reports
// empty; neither changes the node.
// Create, plain push right, rejected operations and operations on an empty
// node go straight to the result; cumulative push right reads the last entry,
// then writes the new one; push left shifts each entry up, last first, then
// writes the new first entry; pop left reads the first entry, then moves each
// other entry down. Entries live in one single-port-write, single-port-read
// memory; push left and pop left walk every entry once, one read and one write
// per cycle; a new operation can be taken the cycle after the result loads.
// A new operation is taken as soon as the previous one has finished, even while
// its result still waits in the output register. If the receiver stalls, the
// finished operation holds until the output register frees up.
// Reset empties the node and sets the leftmost page to zero; memory contents
// are left as they are and are never read before being written.
module cumulative_key_node_deque #(
	parameter int CAPACITY = ckn_pkg::CKN_CAPACITY
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  ckn_pkg::ckn_in_t  in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output ckn_pkg::ckn_out_t out_data
);
	import ckn_pkg::*;

	`include "cumulative_key_node_deque_assert.svh"

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] page;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE, S_PRC, S_SHL, S_SHL0, S_POP0, S_POP, S_FIN
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] count_q;
	logic [31:0] lm_q;
	logic [IDX_W-1:0] ptr_q;
	logic [31:0] key_q;
	logic [31:0] page_q;
	logic [31:0] removed_q;
	logic [1:0] status_q;
	logic out_valid_q;
	ckn_out_t out_data_q;

	entry_t mem [CAPACITY];
	entry_t rd_data_q;
	logic rd_en, wr_en;
	logic [IDX_W-1:0] rd_addr, wr_addr;
	entry_t wr_data;

	logic in_acc, full, empty, out_free;
	logic [CNT_W-1:0] pop_nxt;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc = in_valid && in_ready;
	assign full = (count_q == CNT_W'(CAPACITY));
	assign empty = (count_q == '0);
	assign out_free = !out_valid_q || out_ready;
	assign pop_nxt = CNT_W'(ptr_q) + CNT_W'(2);
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	// memory port control
	always_comb begin
		rd_en = 1'b0;
		rd_addr = '0;
		wr_en = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					unique case (in_data.kind)
						KIND_PUSH_CUM, KIND_PUSH_PLAIN: begin
							if (!full) begin
								if (in_data.kind == KIND_PUSH_CUM && !empty) begin
									rd_en = 1'b1;
									rd_addr = IDX_W'(count_q - 1'b1);
								end else begin
									wr_en = 1'b1;
									wr_addr = IDX_W'(count_q);
									wr_data = '{key: in_data.key, page: in_data.page};
								end
							end
						end
						KIND_PUSH_LEFT: begin
							if (!full) begin
								if (empty) begin
									wr_en = 1'b1;
									wr_addr = '0;
									wr_data = '{key: in_data.key, page: lm_q};
								end else begin
									rd_en = 1'b1;
									rd_addr = IDX_W'(count_q - 1'b1);
								end
							end
						end
						KIND_POP_LEFT: begin
							if (!empty) begin
								rd_en = 1'b1;
								rd_addr = '0;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_PRC: begin
				wr_en = 1'b1;
				wr_addr = IDX_W'(count_q);
				wr_data = '{key: key_q + rd_data_q.key, page: page_q};
			end
			S_SHL: begin
				wr_en = 1'b1;
				wr_addr = ptr_q + 1'b1;
				wr_data = '{key: rd_data_q.key + key_q, page: rd_data_q.page};
				if (ptr_q != '0) begin
					rd_en = 1'b1;
					rd_addr = ptr_q - 1'b1;
				end
			end
			S_SHL0: begin
				wr_en = 1'b1;
				wr_addr = '0;
				wr_data = '{key: key_q, page: lm_q};
			end
			S_POP0: begin
				if (count_q != CNT_W'(1)) begin
					rd_en = 1'b1;
					rd_addr = IDX_W'(1);
				end
			end
			S_POP: begin
				wr_en = 1'b1;
				wr_addr = ptr_q;
				wr_data = '{key: rd_data_q.key - removed_q, page: rd_data_q.page};
				if (pop_nxt != count_q) begin
					rd_en = 1'b1;
					rd_addr = IDX_W'(pop_nxt);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			lm_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						key_q <= in_data.key;
						page_q <= in_data.page;
						removed_q <= '0;
						status_q <= ST_OK;
						state_q <= S_FIN;
						unique case (in_data.kind)
							KIND_CREATE: begin
								count_q <= '0;
								lm_q <= in_data.page;
							end
							KIND_PUSH_CUM, KIND_PUSH_PLAIN: begin
								if (full) begin
									status_q <= ST_FULL;
								end else if (in_data.kind == KIND_PUSH_CUM && !empty) begin
									state_q <= S_PRC;
								end else begin
									count_q <= count_q + 1'b1;
								end
							end
							KIND_PUSH_LEFT: begin
								if (full) begin
									status_q <= ST_FULL;
								end else if (empty) begin
									lm_q <= in_data.page;
									count_q <= count_q + 1'b1;
								end else begin
									ptr_q <= IDX_W'(count_q - 1'b1);
									state_q <= S_SHL;
								end
							end
							KIND_POP_LEFT: begin
								if (empty) begin
									status_q <= ST_EMPTY;
								end else begin
									state_q <= S_POP0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_PRC: begin
					count_q <= count_q + 1'b1;
					state_q <= S_FIN;
				end
				S_SHL: begin
					if (ptr_q == '0) begin
						state_q <= S_SHL0;
					end else begin
						ptr_q <= ptr_q - 1'b1;
					end
				end
				S_SHL0: begin
					lm_q <= page_q;
					count_q <= count_q + 1'b1;
					state_q <= S_FIN;
				end
				S_POP0: begin
					removed_q <= rd_data_q.key;
					lm_q <= rd_data_q.page;
					ptr_q <= '0;
					if (count_q == CNT_W'(1)) begin
						count_q <= '0;
						state_q <= S_FIN;
					end else begin
						state_q <= S_POP;
					end
				end
				S_POP: begin
					if (pop_nxt == count_q) begin
						count_q <= count_q - 1'b1;
						state_q <= S_FIN;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_data_q <= '{
							status: status_q,
							removed_size: removed_q,
							entry_count: 6'(count_q),
							first_page: lm_q
						};
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`CKN_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(CAPACITY))
	`CKN_ASSERT_IMP(a_wr_in_range, clk, arst_n, wr_en, CNT_W'(wr_addr) <= count_q)
	`CKN_ASSERT_IMP(a_no_overlap, clk, arst_n, rd_en && wr_en, rd_addr != wr_addr)
	`CKN_ASSERT_NXT(a_busy_after_transfer, clk, arst_n, in_acc, !in_ready)
	`CKN_ASSERT_NXT(a_result_loaded, clk, arst_n, state_q == S_FIN && out_free,
		out_valid_q && in_ready)

endmodule

/* tb/cumulative_key_node_deque_tb.sv */
`timescale 1ns / 1ps

module cumulative_key_node_deque_tb;
	import ckn_pkg::*;

	localparam int CAPACITY = CKN_CAPACITY;
	localparam logic [2:0] KIND_RESERVED_LO = 3'd5;
	localparam logic [2:0] KIND_RESERVED_MID = 3'd6;
	localparam logic [2:0] KIND_RESERVED_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	ckn_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	ckn_out_t out_data;

	cumulative_key_node_deque dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	// predicted node contents
	logic [31:0] node_keys [CAPACITY];
	logic [31:0] node_pages [CAPACITY];
	int node_count = 0;
	logic [31:0] node_first_page = '0;

	ckn_in_t pending_ops [$];
	ckn_out_t node_results [$];
	ckn_out_t want_result;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int fail_count = 0;
	int gen_count = 0;
	int gen_total = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic ckn_out_t apply_node_op(input ckn_in_t op);
		ckn_out_t res;
		logic [31:0] head_key;
		logic [31:0] head_page;
		int i;
		res = '0;
		res.status = ST_OK;
		case (op.kind)
			KIND_CREATE: begin
				node_count = 0;
				node_first_page = op.page;
			end
			KIND_PUSH_CUM, KIND_PUSH_PLAIN: begin
				if (node_count >= CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					head_key = op.key;
					if (op.kind == KIND_PUSH_CUM && node_count > 0)
						head_key = head_key + node_keys[node_count - 1];
					node_keys[node_count] = head_key;
					node_pages[node_count] = op.page;
					node_count++;
				end
			end
			KIND_PUSH_LEFT: begin
				if (node_count >= CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					for (i = node_count; i > 0; i--) begin
						node_keys[i] = node_keys[i - 1] + op.key;
						node_pages[i] = node_pages[i - 1];
					end
					node_keys[0] = op.key;
					node_pages[0] = node_first_page;
					node_first_page = op.page;
					node_count++;
				end
			end
			KIND_POP_LEFT: begin
				if (node_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					head_key = node_keys[0];
					head_page = node_pages[0];
					for (i = 0; i + 1 < node_count; i++) begin
						node_keys[i] = node_keys[i + 1] - head_key;
						node_pages[i] = node_pages[i + 1];
					end
					node_count--;
					node_first_page = head_page;
					res.removed_size = head_key;
				end
			end
			default: ;
		endcase
		res.entry_count = 6'(node_count);
		res.first_page = node_first_page;
		return res;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return 32'hffff_ffff;
			2: return 32'($urandom_range(0, 15));
			3: return 32'h1 << $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	task automatic enqueue_node_op(input logic [2:0] kind, input logic [31:0] key,
			input logic [31:0] page);
		ckn_in_t op;
		op.kind = kind;
		op.key = key;
		op.page = page;
		pending_ops.push_back(op);
		gen_total++;
		case (kind)
			KIND_CREATE: gen_count = 0;
			KIND_PUSH_CUM, KIND_PUSH_PLAIN, KIND_PUSH_LEFT:
				if (gen_count < CAPACITY) gen_count++;
			KIND_POP_LEFT: if (gen_count > 0) gen_count--;
			default: ;
		endcase
	endtask

	task automatic add_random_ops(input int n_ops);
		int target;
		int pick;
		target = gen_total + n_ops;
		while (gen_total < target) begin
			case ($urandom_range(0, 3))
				0: begin
					// fill to the top, then push into a full node
					while (gen_count < CAPACITY)
						enqueue_node_op(3'($urandom_range(KIND_PUSH_CUM, KIND_PUSH_LEFT)),
							rand_word(), rand_word());
					repeat ($urandom_range(1, 3))
						enqueue_node_op(3'($urandom_range(KIND_PUSH_CUM, KIND_PUSH_LEFT)),
							rand_word(), rand_word());
				end
				1: begin
					while (gen_count > 0)
						enqueue_node_op(KIND_POP_LEFT, rand_word(), rand_word());
					repeat ($urandom_range(1, 2))
						enqueue_node_op(KIND_POP_LEFT, rand_word(), rand_word());
				end
				default: begin
					repeat ($urandom_range(4, 40)) begin
						pick = $urandom_range(0, 99);
						if (pick < 3)
							enqueue_node_op(KIND_CREATE, rand_word(), rand_word());
						else if (pick < 6)
							enqueue_node_op(3'($urandom_range(KIND_RESERVED_LO, KIND_RESERVED_HI)),
								rand_word(), rand_word());
						else if (pick < 55)
							enqueue_node_op(3'($urandom_range(KIND_PUSH_CUM, KIND_PUSH_LEFT)),
								rand_word(), rand_word());
						else
							enqueue_node_op(KIND_POP_LEFT, rand_word(), rand_word());
					end
				end
			endcase
		end
	endtask

	task automatic drain_node();
		while (pending_ops.size() != 0 || in_valid || node_results.size() != 0)
			@(posedge clk);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready)
				node_results.push_back(apply_node_op(in_data));
			if (!in_valid || in_ready) begin
				if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= pending_ops.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (node_results.size() == 0) begin
					$error("result transfer with nothing pending: %p", out_data);
					fail_count++;
				end else begin
					want_result = node_results.pop_front();
					if (out_data.status !== want_result.status) begin
						$error("status: expected %0d, got %0d", want_result.status,
							out_data.status);
						fail_count++;
					end
					if (out_data.removed_size !== want_result.removed_size) begin
						$error("removed_size: expected %h, got %h", want_result.removed_size,
							out_data.removed_size);
						fail_count++;
					end
					if (out_data.entry_count !== want_result.entry_count) begin
						$error("entry_count: expected %0d, got %0d", want_result.entry_count,
							out_data.entry_count);
						fail_count++;
					end
					if (out_data.first_page !== want_result.first_page) begin
						$error("first_page: expected %h, got %h", want_result.first_page,
							out_data.first_page);
						fail_count++;
					end
				end
			end
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		#7_200_000;
		$display("cumulative_key_node_deque verification failed");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 18;
		recv_idle_pct = 52;

		// empty pop and push left right after reset
		enqueue_node_op(KIND_POP_LEFT, 32'hffff_ffff, 32'hffff_ffff);
		enqueue_node_op(KIND_PUSH_LEFT, 32'h5, 32'h1234_5678);
		enqueue_node_op(KIND_CREATE, 32'h0, 32'hffff_ffff);
		// cumulative push on empty node, then key wrap
		enqueue_node_op(KIND_PUSH_CUM, 32'hffff_ffff, 32'h1);
		enqueue_node_op(KIND_PUSH_CUM, 32'h1, 32'h2);
		enqueue_node_op(KIND_PUSH_PLAIN, 32'hffff_ffff, 32'hffff_ffff);
		enqueue_node_op(KIND_PUSH_LEFT, 32'hffff_ffff, 32'h0);
		enqueue_node_op(KIND_PUSH_CUM, 32'h0, 32'h3);
		enqueue_node_op(KIND_POP_LEFT, 32'h0, 32'h0);
		enqueue_node_op(KIND_POP_LEFT, 32'h0, 32'h0);
		// unknown kinds leave the node alone
		enqueue_node_op(KIND_RESERVED_LO, 32'hffff_ffff, 32'hffff_ffff);
		enqueue_node_op(KIND_RESERVED_MID, 32'hffff_ffff, 32'hffff_ffff);
		enqueue_node_op(KIND_RESERVED_HI, 32'hffff_ffff, 32'hffff_ffff);
		enqueue_node_op(KIND_POP_LEFT, 32'h0, 32'h0);
		enqueue_node_op(KIND_POP_LEFT, 32'h0, 32'h0);
		enqueue_node_op(KIND_POP_LEFT, 32'h0, 32'h0);
		enqueue_node_op(KIND_POP_LEFT, 32'h0, 32'h0);
		enqueue_node_op(KIND_CREATE, 32'hffff_ffff, 32'h0);
		enqueue_node_op(KIND_PUSH_PLAIN, 32'h0, 32'h0);
		enqueue_node_op(KIND_PUSH_LEFT, 32'h0, 32'h0);
		enqueue_node_op(KIND_POP_LEFT, 32'h0, 32'h0);
		enqueue_node_op(KIND_POP_LEFT, 32'h0, 32'h0);
		enqueue_node_op(KIND_POP_LEFT, 32'h0, 32'h0);
		drain_node();

		add_random_ops(250);
		drain_node();

		send_idle_pct = 52;
		recv_idle_pct = 18;
		add_random_ops(250);
		drain_node();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		add_random_ops(250);
		drain_node();

		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("cumulative_key_node_deque verification clean");
		else
			$display("cumulative_key_node_deque verification failed");
		$finish;
	end

endmodule
